[rtl/fnvht_pkg.sv]
// fnvht_pkg: shared types and constants for the fnv-1a linear probe hash table
// used by the ctrl, dp, top level and checker files; no dependencies
`default_nettype none
package fnvht_pkg;
    localparam int          SLOTS_DEF      = 256;
    localparam int          VALUE_BITS_DEF = 32;
    localparam logic [63:0] HASH_BASIS     = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME     = 64'h00000100000001b3;
    // prime split as 2**40 + low part, so the multiply is a shift plus a small product
    localparam int          HASH_PRIME_SHIFT = 40;
    localparam logic [8:0]  HASH_PRIME_LO    = 9'h1b3;
    localparam logic [3:0]  KEY_BYTES_RST  = 4'd8;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_MULT,
        S_PROBE,
        S_CHECK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic hash_mix;  // xor next byte, register for multiply
        logic hash_mul;  // multiply step, advance byte counter
        logic probe_init;// set probe index to start slot
        logic probe_rd;  // marks the probe state; the datapath does not use it, the memories always read at probe index
        logic probe_adv; // next slot
        logic do_write;  // write key and value at probe index, set occupied
        logic do_free;   // clear occupied at probe index
        logic set_hit;   // result hit at probe index
        logic set_miss;  // result miss
        logic set_full;  // result full
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       hash_done;
        logic       occ;     // occupied bit of probed slot
        logic       match;   // stored key matches
        logic       at_end;  // probe index is the last slot
    } t_stat;
endpackage
`default_nettype wire

[rtl/fnvht_ram.sv]
// fnvht_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module fnvht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/fnvht_ctrl.sv]
// fnvht_ctrl: operation sequencer state machine
// depends on fnvht_pkg
`default_nettype none
module fnvht_ctrl import fnvht_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_PROBE;
                end else begin
                    o_cmd.hash_mix = 1'b1;
                    n_state        = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.hash_mul = 1'b1;
                n_state        = S_HASH;
            end
            S_PROBE: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_OUT;
                case (i_stat.op)
                    OP_FIND, OP_DELETE: begin
                        if (i_stat.occ && i_stat.match) begin
                            o_cmd.set_hit = 1'b1;
                            o_cmd.do_free = (i_stat.op == OP_DELETE);
                        end else if (i_stat.at_end) begin
                            o_cmd.set_miss = 1'b1;
                        end else begin
                            o_cmd.probe_adv = 1'b1;
                            n_state         = S_PROBE;
                        end
                    end
                    OP_INSERT: begin
                        if (!i_stat.occ) begin
                            o_cmd.set_hit  = 1'b1;
                            o_cmd.do_write = 1'b1;
                        end else if (i_stat.at_end) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.probe_adv = 1'b1;
                            n_state         = S_PROBE;
                        end
                    end
                    default: o_cmd.set_miss = 1'b1;
                endcase
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/fnvht_dp.sv]
// fnvht_dp: hash, probe index, key/value memories, occupied bits, result register
// depends on fnvht_pkg and fnvht_ram
`default_nettype none
module fnvht_dp import fnvht_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [1:0]       o_status,
    output logic [31:0]      o_value_out,
    output logic [7:0]       o_slot
);
    localparam int AW = $clog2(SLOTS);

    logic [3:0]            r_key_bytes;
    logic [1:0]            r_op;
    logic [63:0]           r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [3:0]            r_len;
    logic [3:0]            r_cnt;
    logic [63:0]           r_hash;
    logic [63:0]           r_mix;
    logic [AW-1:0]         r_idx;
    logic [SLOTS-1:0]      r_occ;
    logic [63:0]           mask;
    logic [63:0]           key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [7:0]            cur_byte;
    logic [31:0]           val_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= KEY_BYTES_RST;
        end else if (i_cfg_we) begin
            r_key_bytes <= i_cfg_data;
        end
    end

    always_comb begin
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < r_len) begin
                mask[8*b +: 8] = 8'hff;
            end
        end
        cur_byte = r_key[8*r_cnt[2:0] +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_key  <= i_key;
            r_val  <= VALUE_BITS'(i_value);
            r_len  <= (r_key_bytes > 4'd8) ? 4'd8 : r_key_bytes;
            r_cnt  <= '0;
            r_hash <= HASH_BASIS;
        end
        if (i_cmd.hash_mix) begin
            r_mix <= r_hash ^ {56'd0, cur_byte};
        end
        if (i_cmd.hash_mul) begin
            r_hash <= (r_mix << HASH_PRIME_SHIFT) + (r_mix * {55'd0, HASH_PRIME_LO});
            r_cnt  <= r_cnt + 4'd1;
        end
        if (i_cmd.probe_init) begin
            r_idx <= r_hash[AW-1:0];
        end else if (i_cmd.probe_adv) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.do_write) begin
            r_occ[r_idx] <= 1'b1;
        end else if (i_cmd.do_free) begin
            r_occ[r_idx] <= 1'b0;
        end
    end

    fnvht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_write),
        .i_addr  (r_idx),
        .i_wdata (r_key),
        .o_rdata (key_rd)
    );

    fnvht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_write),
        .i_addr  (r_idx),
        .i_wdata (r_val),
        .o_rdata (val_rd)
    );

    assign val_ext = 32'(val_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_hit) begin
            o_status    <= ST_OK;
            o_value_out <= (r_op == OP_FIND) ? val_ext : 32'd0;
            o_slot      <= 8'(r_idx);
        end else if (i_cmd.set_miss || i_cmd.set_full) begin
            o_status    <= i_cmd.set_full ? ST_FULL : ST_MISS;
            o_value_out <= '0;
            o_slot      <= '0;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.hash_done = (r_cnt == r_len);
    assign o_stat.occ       = r_occ[r_idx];
    assign o_stat.match     = ((key_rd ^ r_key) & mask) == 64'd0;
    assign o_stat.at_end    = (r_idx == AW'(SLOTS - 1));
endmodule
`default_nettype wire

[rtl/fnv_linear_probe_hash_table.sv]
// fnv_linear_probe_hash_table: top level, controller plus datapath
// depends on fnvht_pkg, fnvht_ctrl, fnvht_dp
//
// channel | dir | beat fields
// s_axis  | in  | tdata: op[1:0], key[65:2], value[97:66], pad to 104
// m_axis  | out | tdata: status[1:0], value_out[33:2], slot[41:34], pad to 48
// cfg     | in  | key_bytes on i_cfg_data when i_cfg_we
//
// per item: load, then a mix and a multiply state per key byte (serial byte hash),
// then a probe and a check state per slot read, then the output handshake
// one item at a time; s_axis_tready high only when idle
// result is held on m_axis until taken
// reset clears key_bytes to 8 and all occupied bits at once
`default_nettype none
module fnv_linear_probe_hash_table import fnvht_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [3:0]   i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // op, key, value
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata   // status, value_out, slot
);
    t_cmd        cmd;
    t_stat       stat;
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [7:0]  slot;

    fnvht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fnvht_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tdata[1:0]),
        .i_key       (s_axis_tdata[65:2]),
        .i_value     (s_axis_tdata[97:66]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (status),
        .o_value_out (value_out),
        .o_slot      (slot)
    );

    assign m_axis_tdata = {6'd0, slot, value_out, status};
endmodule
`default_nettype wire

[rtl/fnvht_checker.sv]
// fnvht_checker: port-level assertions for the hash table, bound to the top level
// depends on fnvht_pkg
`default_nettype none
module fnvht_checker import fnvht_pkg::*; (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [47:0]  m_axis_tdata
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[41:2] == 40'd0)
        else $error("miss result carries data");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted twice");
endmodule

bind fnv_linear_probe_hash_table fnvht_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
